// File: rtl/gbb_pkg.sv
// Package with the shared types and constants of the glyph bitmap blitter.
`default_nettype none
package gbb_pkg;

  localparam int OFS_W   = 26;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 12;
  localparam int ORG_W   = 13;
  localparam int SCR_W   = 13;
  localparam int CFG_A_W = 3;

  localparam logic [SCR_W-1:0] SCR_W_RST = 13'd800;
  localparam logic [SCR_W-1:0] SCR_H_RST = 13'd480;

  typedef enum logic [1:0] {
    FMT_8   = 2'd0,
    FMT_16  = 2'd1,
    FMT_32  = 2'd2,
    FMT_RSV = 2'd3
  } gbb_fmt_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_GLYPH_W   = 3'd2,
    REG_GLYPH_H   = 3'd3,
    REG_COLOR     = 3'd4,
    REG_FORMAT    = 3'd5,
    REG_SCREEN_W  = 3'd6,
    REG_SCREEN_H  = 3'd7
  } gbb_reg_t;

  typedef struct packed {
    logic              valid;
    logic [OFS_W-1:0]  offset;
    logic [DATA_W-1:0] data;
    logic [1:0]        size;
  } gbb_wr_t;

endpackage
`default_nettype wire

// File: rtl/gbb_wr_fmt.sv
// Framebuffer write formatter: byte offset and pixel data for one glyph pixel.
`default_nettype none
module gbb_wr_fmt #(
  parameter int MAX_RES = 4096
) (
  input  wire logic                          wr,
  input  wire logic [$clog2(MAX_RES)-1:0]    x,
  input  wire logic [$clog2(MAX_RES)-1:0]    y,
  input  wire logic [$clog2(MAX_RES+1)-1:0]  sw,
  input  wire gbb_pkg::gbb_fmt_t             fmt,
  input  wire logic [gbb_pkg::DATA_W-1:0]    color,
  output gbb_pkg::gbb_wr_t                   res
);
  import gbb_pkg::*;

  localparam int CRD_W = $clog2(MAX_RES);
  localparam int RES_W = $clog2(MAX_RES + 1);
  localparam int SUM_W = (CRD_W + RES_W + 3 > OFS_W) ? CRD_W + RES_W + 3 : OFS_W;

  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] scaled;
  logic             fmt_ok;
  logic [DATA_W-1:0] data;

  assign prod = SUM_W'(y) * SUM_W'(sw);
  assign base = prod + SUM_W'(x);

  always_comb begin
    fmt_ok = 1'b1;
    scaled = base;
    data   = color;
    case (fmt)
      FMT_8: begin
        scaled = base;
        data   = {24'd0, color[7:0]};
      end
      FMT_16: begin
        scaled = base << 1;
        data   = {16'd0, color[23:19], color[15:10], color[7:3]};
      end
      FMT_32: begin
        scaled = base << 2;
        data   = color;
      end
      default: begin
        fmt_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.valid  = wr && fmt_ok;
    res.offset = res.valid ? scaled[OFS_W-1:0] : '0;
    res.data   = res.valid ? data : '0;
    res.size   = fmt_ok ? fmt : FMT_8;
  end

endmodule
`default_nettype wire

// File: rtl/glyph_bitmap_blitter.sv
// Top level of the glyph bitmap blitter: counters, clipping and the output stage.
//
//   channel  direction  contents
//   in_      slave      one glyph mask byte per word
//   out_     master     one framebuffer write per word, tlast on the last glyph pixel
//   cfg_     slave      register index and write data, always ready
//
// Each accepted input word gives one output word through the clip and output registers.
// The block takes one word per cycle while not stalled; the limit is the single pass through
// the row-times-width multiplier between the clip register and the output register.
// Reset clears the counters and the pipeline valids and loads the register defaults.
// A stall on the output holds both stages and removes in_tready only once they are full.
`default_nettype none
module glyph_bitmap_blitter #(
  parameter int MAX_RES = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,   // mask_value
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [63:0]                    out_tdata,  // byte_offset, write_data, zero pad
  output      logic [2:0]                     out_tuser,  // write_valid, write_size
  output      logic                           out_tlast,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [gbb_pkg::CFG_A_W-1:0]    cfg_addr,
  input  wire logic [gbb_pkg::DATA_W-1:0]     cfg_data
);
  import gbb_pkg::*;

  localparam int CRD_W = $clog2(MAX_RES);
  localparam int RES_W = $clog2(MAX_RES + 1);

  logic signed [ORG_W-1:0] org_x_r, org_y_r;
  logic [CNT_W-1:0]        gw_r, gh_r;
  logic [DATA_W-1:0]       color_r;
  gbb_fmt_t                fmt_r;
  logic [SCR_W-1:0]        scr_w_r, scr_h_r;

  logic [CNT_W-1:0]        col_r, col_nxt, row_r, row_nxt;

  logic                    a_v_r, a_v_nxt;
  logic                    a_wr_r, a_done_r;
  logic [CRD_W-1:0]        a_x_r, a_y_r;

  logic                    out_v_r, out_v_nxt;
  gbb_wr_t                 out_wr_r;
  logic                    out_done_r;

  logic                    in_acc, ready_a, ready_b;
  logic [RES_W-1:0]        sw_c, sh_c;
  logic signed [ORG_W:0]   x_s, y_s;
  logic                    x_on, y_on, in_glyph, row_end, done;
  gbb_wr_t                 wr_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      gw_r    <= '0;
      gh_r    <= '0;
      color_r <= '0;
      fmt_r   <= FMT_32;
      scr_w_r <= SCR_W_RST;
      scr_h_r <= SCR_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (gbb_reg_t'(cfg_addr))
        REG_ORIGIN_X: org_x_r <= $signed(cfg_data[ORG_W-1:0]);
        REG_ORIGIN_Y: org_y_r <= $signed(cfg_data[ORG_W-1:0]);
        REG_GLYPH_W:  gw_r    <= cfg_data[CNT_W-1:0];
        REG_GLYPH_H:  gh_r    <= cfg_data[CNT_W-1:0];
        REG_COLOR:    color_r <= cfg_data;
        REG_FORMAT:   fmt_r   <= gbb_fmt_t'(cfg_data[1:0]);
        REG_SCREEN_W: scr_w_r <= cfg_data[SCR_W-1:0];
        REG_SCREEN_H: scr_h_r <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign ready_b   = !out_v_r || out_tready;
  assign ready_a   = !a_v_r || ready_b;
  assign in_tready = ready_a;
  assign in_acc    = in_tvalid && ready_a;

  assign sw_c = (14'(scr_w_r) > 14'(MAX_RES)) ? RES_W'(MAX_RES) : RES_W'(scr_w_r);
  assign sh_c = (14'(scr_h_r) > 14'(MAX_RES)) ? RES_W'(MAX_RES) : RES_W'(scr_h_r);

  assign x_s  = $signed({org_x_r[ORG_W-1], org_x_r}) + $signed({2'b00, col_r});
  assign y_s  = $signed({org_y_r[ORG_W-1], org_y_r}) + $signed({2'b00, row_r});
  assign x_on = !x_s[ORG_W] && (14'(x_s[ORG_W-1:0]) < 14'(sw_c));
  assign y_on = !y_s[ORG_W] && (14'(y_s[ORG_W-1:0]) < 14'(sh_c));

  assign in_glyph = (col_r < gw_r) && (row_r < gh_r);
  assign row_end  = ({1'b0, col_r} + 13'd1) >= {1'b0, gw_r};
  assign done     = row_end && (({1'b0, row_r} + 13'd1) >= {1'b0, gh_r});

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (done) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 12'd1;
      end else begin
        col_nxt = col_r + 12'd1;
      end
    end
  end

  assign a_v_nxt   = in_acc ? 1'b1 : (ready_b ? 1'b0 : a_v_r);
  assign out_v_nxt = ready_b ? a_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      a_v_r   <= a_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_wr_r   <= in_glyph && x_on && y_on && (in_tdata != 8'd0);
      a_done_r <= done;
      a_x_r    <= x_s[CRD_W-1:0];
      a_y_r    <= y_s[CRD_W-1:0];
    end
    if (ready_b && a_v_r) begin
      out_wr_r   <= wr_res;
      out_done_r <= a_done_r;
    end
  end

  gbb_wr_fmt #(
    .MAX_RES (MAX_RES)
  ) u_wr_fmt (
    .wr    (a_wr_r),
    .x     (a_x_r),
    .y     (a_y_r),
    .sw    (sw_c),
    .fmt   (fmt_r),
    .color (color_r),
    .res   (wr_res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_wr_r.data, out_wr_r.offset};
  assign out_tuser  = {out_wr_r.size, out_wr_r.valid};
  assign out_tlast  = out_done_r;

  a_wr_fmt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_wr_r.valid |-> out_wr_r.size != FMT_RSV)
    else $error("write issued with the reserved pixel format");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_wr_r.valid |-> out_wr_r.offset == '0 && out_wr_r.data == '0)
    else $error("skipped pixel carries a nonzero offset or data");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && done |=> col_r == '0 && row_r == '0)
    else $error("counters not cleared after the last glyph pixel");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !ready_b |=> a_v_r && $stable(a_wr_r) && $stable(a_done_r))
    else $error("clip stage lost a word during an output stall");

  a_no_count_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(col_r) && $stable(row_r))
    else $error("glyph counters moved without an accepted word");

endmodule
`default_nettype wire

// File: verif/glyph_bitmap_blitter_tb.sv
// Self-checking testbench for the glyph bitmap blitter with a predicting scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module glyph_bitmap_blitter_tb;
  import gbb_pkg::*;

  localparam int MAX_RES = 4096;

  typedef struct packed {
    logic              wv;
    logic [OFS_W-1:0]  ofs;
    logic [DATA_W-1:0] data;
    logic [1:0]        size;
    logic              done;
  } blit_write_t;

  class glyph_scoreboard;
    int          org_x;
    int          org_y;
    int          glyph_w;
    int          glyph_h;
    logic [31:0] color;
    gbb_fmt_t    pix_fmt;
    int          scr_w;
    int          scr_h;
    int          col;
    int          row;
    blit_write_t pending_writes[$];
    int          errors;
    int          checked;
    int          drawn;
    int          blanked;
    int          glyphs;

    function new();
      org_x   = 0;
      org_y   = 0;
      glyph_w = 0;
      glyph_h = 0;
      color   = '0;
      pix_fmt = FMT_32;
      scr_w   = 800;
      scr_h   = 480;
      col     = 0;
      row     = 0;
      errors  = 0;
      checked = 0;
      drawn   = 0;
      blanked = 0;
      glyphs  = 0;
    endfunction

    function void set_reg(gbb_reg_t idx, logic [31:0] v);
      case (idx)
        REG_ORIGIN_X: org_x = int'($signed(v[12:0]));
        REG_ORIGIN_Y: org_y = int'($signed(v[12:0]));
        REG_GLYPH_W:  glyph_w = int'(v[11:0]);
        REG_GLYPH_H:  glyph_h = int'(v[11:0]);
        REG_COLOR:    color = v;
        REG_FORMAT:   pix_fmt = gbb_fmt_t'(v[1:0]);
        REG_SCREEN_W: scr_w = int'(v[12:0]);
        REG_SCREEN_H: scr_h = int'(v[12:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function void note_mask(logic [7:0] mask);
      blit_write_t w;
      int          x;
      int          y;
      int          sw;
      int          sh;
      int          bpp;
      logic        in_glyph;
      logic        on_screen;
      logic        fmt_ok;
      logic        row_end;
      longint      ofs;
      x         = org_x + col;
      y         = org_y + row;
      sw        = (scr_w > MAX_RES) ? MAX_RES : scr_w;
      sh        = (scr_h > MAX_RES) ? MAX_RES : scr_h;
      in_glyph  = (col < glyph_w) && (row < glyph_h);
      on_screen = (x >= 0) && (y >= 0) && (x < sw) && (y < sh);
      fmt_ok    = (pix_fmt != FMT_RSV);
      w         = '0;
      w.wv      = in_glyph && on_screen && fmt_ok && (mask != 8'h00);
      w.size    = fmt_ok ? pix_fmt : FMT_8;
      bpp       = 1 << w.size;
      row_end   = (col + 1 >= glyph_w);
      w.done    = row_end && (row + 1 >= glyph_h);
      if (w.wv) begin
        ofs   = longint'(y) * longint'(sw * bpp) + longint'(x * bpp);
        w.ofs = ofs[OFS_W-1:0];
        case (w.size)
          FMT_8:   w.data = {24'h0, color[7:0]};
          FMT_16:  w.data = {16'h0, color[23:19], color[15:10], color[7:3]};
          default: w.data = color;
        endcase
        drawn++;
      end else begin
        blanked++;
      end
      if (w.done) begin
        col = 0;
        row = 0;
        glyphs++;
      end else if (row_end) begin
        col = 0;
        row = (row + 1) & 12'hFFF;
      end else begin
        col = (col + 1) & 12'hFFF;
      end
      pending_writes.push_back(w);
    endfunction

    function void same(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_write(logic [63:0] tdata, logic [2:0] tuser, logic tlast);
      blit_write_t want;
      if (pending_writes.size() == 0) begin
        $error("Output word with nothing expected: tdata %h tuser %h", tdata, tuser);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      checked++;
      same("write_valid", 32'(want.wv), 32'(tuser[0]));
      same("byte_offset", 32'(want.ofs), 32'(tdata[OFS_W-1:0]));
      same("write_data", want.data, tdata[OFS_W+DATA_W-1:OFS_W]);
      same("write_size", 32'(want.size), 32'(tuser[2:1]));
      same("glyph_done", 32'(want.done), 32'(tlast));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // mask_value
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // byte_offset, write_data, zero pad
  logic [2:0]  out_tuser;   // write_valid, write_size
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [DATA_W-1:0]  cfg_data;

  glyph_scoreboard books;
  bit              steady;
  bit              stall_request;
  bit              long_stall;
  bit              long_stall_done;
  int              items_sent;
  int              setups;

  glyph_bitmap_blitter #(.MAX_RES(MAX_RES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [12:0] pick_res();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 13'd1;
    if (r == 1) return 13'd4096;
    if (r == 2) return 13'($urandom_range(1, 4096));
    return 13'($urandom_range(2, 40));
  endfunction

  function automatic logic [12:0] pick_origin(int res);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 13'h1000;
    if (r == 1) return 13'h0FFF;
    if (r == 2) return 13'($urandom_range(0, 8191));
    return 13'(int'($urandom_range(0, res + 8)) - 6);
  endfunction

  task automatic send_mask(input logic [7:0] mask);
    int g;
    g = pick_gap();
    if (g > 0 && !long_stall) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= mask;
    do @(posedge clk); while (!in_tready);
    books.note_mask(mask);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_masks(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) send_mask(8'($urandom_range(1, 255)));
      else send_mask(8'h00);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (books.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input gbb_reg_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    books.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic apply_setup(input logic [12:0] ox, input logic [12:0] oy,
                             input logic [11:0] gw, input logic [11:0] gh,
                             input logic [31:0] color, input gbb_fmt_t fmt,
                             input logic [12:0] sw, input logic [12:0] sh);
    drain();
    put_reg(REG_ORIGIN_X, 32'(ox));
    put_reg(REG_ORIGIN_Y, 32'(oy));
    put_reg(REG_GLYPH_W, 32'(gw));
    put_reg(REG_GLYPH_H, 32'(gh));
    put_reg(REG_COLOR, color);
    put_reg(REG_FORMAT, 32'(fmt));
    put_reg(REG_SCREEN_W, 32'(sw));
    put_reg(REG_SCREEN_H, 32'(sh));
    cfg_valid <= 1'b0;
    setups++;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!long_stall_done && stall_request) begin
        long_stall = 1'b1;
        out_tready <= 1'b0;
        repeat (80) @(negedge clk);
        long_stall      = 1'b0;
        long_stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk);
      if (out_tvalid && out_tready) books.check_write(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin
    logic [12:0] sw;
    logic [12:0] sh;
    logic [11:0] gw;
    logic [11:0] gh;
    int          r;
    int          cells;
    int          n;
    books      = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_addr   = REG_ORIGIN_X;
    cfg_data   = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings describe an empty glyph, so every word ends it.
    send_mask(8'hFF);
    send_mask(8'h01);

    apply_setup(13'd0, 13'd0, 12'd3, 12'd1, 32'hFFFF_FFFF, FMT_8, 13'd4096, 13'd1);
    send_mask(8'h80);
    send_mask(8'h00);
    send_mask(8'hFF);
    apply_setup(13'd0, 13'd0, 12'd3, 12'd1, 32'h00FF_8040, FMT_16, 13'd4096, 13'd1);
    send_mask(8'h7F);
    send_mask(8'h55);
    send_mask(8'hAA);
    apply_setup(13'd0, 13'd0, 12'd3, 12'd1, 32'h0000_0000, FMT_32, 13'd4096, 13'd1);
    send_mask(8'h01);
    send_mask(8'h00);
    send_mask(8'h02);

    apply_setup(13'h1000, 13'h1000, 12'd2, 12'd2, 32'h00A5_5A3C, FMT_32, 13'd1, 13'd1);
    repeat (4) send_mask(8'hFF);

    apply_setup(13'h0FFF, 13'h0FFF, 12'd2, 12'd1, 32'h0012_3456, FMT_32, 13'd4096, 13'd4096);
    send_mask(8'hFF);
    send_mask(8'hFF);

    // Shrinking the glyph mid-row leaves the column counter past the new width.
    apply_setup(13'd0, 13'd0, 12'd4095, 12'd4095, 32'h00C0_FFEE, FMT_16, 13'd16, 13'd16);
    send_mask(8'h10);
    send_mask(8'h20);
    send_mask(8'h40);
    apply_setup(13'd0, 13'd0, 12'd2, 12'd1, 32'h00C0_FFEE, FMT_16, 13'd16, 13'd16);
    send_mask(8'hFF);
    apply_setup(13'd1, 13'd1, 12'd0, 12'd2, 32'h0000_00FF, FMT_8, 13'd16, 13'd16);
    send_mask(8'hFF);
    send_mask(8'hFF);

    while (items_sent < 1225) begin
      sw = pick_res();
      sh = pick_res();
      r  = $urandom_range(0, 9);
      gw = (r == 0) ? 12'd0 : (r == 1) ? 12'($urandom_range(9, 4095))
                                       : 12'($urandom_range(1, 8));
      r  = $urandom_range(0, 9);
      gh = (r == 0) ? 12'd0 : (r == 1) ? 12'($urandom_range(7, 4095))
                                       : 12'($urandom_range(1, 6));
      apply_setup(pick_origin(int'(sw)), pick_origin(int'(sh)), gw, gh, $urandom,
                  gbb_fmt_t'($urandom_range(0, 2)), sw, sh);
      steady = ($urandom_range(0, 3) == 0);
      cells  = int'(gw) * int'(gh);
      if (cells == 0) n = $urandom_range(1, 4);
      else if (cells > 48) n = $urandom_range(1, 48);
      else if ($urandom_range(0, 6) == 0) n = $urandom_range(1, cells + 3);
      else n = cells * $urandom_range(1, 3);
      // The long output stall starts with this batch, which is long enough to fill the block.
      if (!stall_request && items_sent >= 400) begin
        stall_request = 1'b1;
        n = n + 24;
      end
      send_random_masks(n);
    end
    steady = 1'b0;

    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d mask words over %0d register settings: %0d pixel writes, %0d blank or clipped.",
             items_sent, setups, books.drawn, books.blanked);
    $display("Completed %0d glyphs and checked %0d output words.", books.glyphs, books.checked);
    if (books.errors == 0 && books.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d output words still expected.", books.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/gbb_pkg.sv
rtl/gbb_wr_fmt.sv
rtl/glyph_bitmap_blitter.sv
verif/glyph_bitmap_blitter_tb.sv
